[rtl/uvi_pkg.sv]
// Shared constants and types for the unique value indexer.
package uvi_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_ELEMENTS = 65536;

  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 8;
  localparam int POS_W   = 16;
  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] slot;
  } search_tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

[rtl/uvi_cell.sv]
// One table entry of the compare chain: holds a value and passes the search token on.
module uvi_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uvi_pkg::IDX_W-1:0]     index,
  input  logic [uvi_pkg::VALUE_W-1:0]   key,
  input  logic [uvi_pkg::USED_W-1:0]    used,
  input  logic                          wr_en,
  input  logic [uvi_pkg::IDX_W-1:0]     wr_slot,
  input  logic [uvi_pkg::VALUE_W-1:0]   wr_data,
  input  uvi_pkg::search_tok_t          tok_in,
  output uvi_pkg::search_tok_t          tok_out
);

  logic [uvi_pkg::VALUE_W-1:0] stored;
  logic                        match;

  assign match = (uvi_pkg::USED_W'(index) < used) && (stored == key);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == index)) begin
      stored <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.active <= tok_in.active;
      tok_out.hit    <= tok_in.hit | match;
      tok_out.slot   <= tok_in.hit ? tok_in.slot : index;
    end
  end

endmodule

[rtl/unique_value_indexer.sv]
// Top level of the unique value indexer: control, counters and the chain of table cells.
//
// Each item walks a chain of TABLE_DEPTH compare cells, one cell per cycle: the accepted
// item is registered as a launch token, passes through the register of every cell, and
// its result is then registered onto the result ports.
// The block takes one item at a time and holds busy high while an item is in the chain
// and during reset.
// Each result is shown for exactly one cycle with done high and must be taken then, since
// the receiver cannot stall the block. A new value is written into its table cell in the
// same cycle that its result is registered.
module unique_value_indexer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [uvi_pkg::VALUE_W-1:0]  sample_value,
  input  logic                                start_req,
  output logic                                done,
  output logic [uvi_pkg::SLOT_W-1:0]          slot_index,
  output logic                                is_new,
  output logic signed [uvi_pkg::VALUE_W-1:0]  unique_value,
  output logic [uvi_pkg::POS_W-1:0]           element_position,
  output logic                                overflow
);

  uvi_pkg::state_t                state, state_next;
  logic                           accept;
  logic                           launch;
  logic                           finish;
  logic [uvi_pkg::VALUE_W-1:0]    key;
  logic [uvi_pkg::USED_W-1:0]     used_slots;
  logic [uvi_pkg::COUNT_W-1:0]    element_counter;
  uvi_pkg::search_tok_t           tok [0:uvi_pkg::TABLE_DEPTH];
  uvi_pkg::search_tok_t           tail;

  logic                           pos_limit;
  logic                           table_full;
  logic                           insert;
  logic [uvi_pkg::IDX_W-1:0]      slot_sel;
  logic                           ovf_sel;

  assign accept = start && !busy;
  assign tail   = tok[uvi_pkg::TABLE_DEPTH];

  always_comb begin
    state_next = state;
    case (state)
      uvi_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = uvi_pkg::ST_SEARCH;
        end
      end
      uvi_pkg::ST_SEARCH: begin
        if (tail.active) begin
          state_next = uvi_pkg::ST_IDLE;
        end
      end
      default: state_next = uvi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = rst;
    finish = 1'b0;
    case (state)
      uvi_pkg::ST_IDLE: begin
        busy   = rst;
        finish = 1'b0;
      end
      uvi_pkg::ST_SEARCH: begin
        busy   = 1'b1;
        finish = tail.active;
      end
      default: begin
        busy   = rst;
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= uvi_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= sample_value;
    end
  end

  assign tok[0] = '{active: launch, hit: 1'b0, slot: '0};

  for (genvar k = 0; k < uvi_pkg::TABLE_DEPTH; k++) begin : g_cell
    uvi_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .index   (uvi_pkg::IDX_W'(k)),
      .key     (key),
      .used    (used_slots),
      .wr_en   (insert),
      .wr_slot (used_slots[uvi_pkg::IDX_W-1:0]),
      .wr_data (key),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign pos_limit  = element_counter >= uvi_pkg::COUNT_W'(uvi_pkg::MAX_ELEMENTS);
  assign table_full = used_slots >= uvi_pkg::USED_W'(uvi_pkg::TABLE_DEPTH);
  assign insert     = finish && !pos_limit && !tail.hit && !table_full;

  always_comb begin
    slot_sel = '0;
    ovf_sel  = 1'b0;
    if (pos_limit) begin
      ovf_sel = 1'b1;
      if (tail.hit) begin
        slot_sel = tail.slot;
      end
    end else if (tail.hit) begin
      slot_sel = tail.slot;
    end else if (!table_full) begin
      slot_sel = used_slots[uvi_pkg::IDX_W-1:0];
    end else begin
      ovf_sel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots      <= '0;
      element_counter <= '0;
      done            <= 1'b0;
    end else begin
      done <= finish;
      if (accept && start_req) begin
        used_slots      <= '0;
        element_counter <= '0;
      end else if (finish) begin
        if (insert) begin
          used_slots <= used_slots + uvi_pkg::USED_W'(1);
        end
        if (!pos_limit) begin
          element_counter <= element_counter + uvi_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      slot_index   <= uvi_pkg::SLOT_W'(slot_sel);
      is_new       <= insert;
      unique_value <= key;
      overflow     <= ovf_sel;
      if (pos_limit) begin
        element_position <= '1;
      end else begin
        element_position <= uvi_pkg::POS_W'(element_counter);
      end
    end
  end

endmodule
